// File: rtl/pve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pve_pkg - shared types and constants for the prefix varint encoder
// Length codes, the job record passed from the classifier to the serialiser,
// and the fixed tag constants of the encoding.
// ----------------------------------------------------------------------------
package pve_pkg;

    // Encoded length of one value
    typedef enum logic [2:0] {
        LEN_1,
        LEN_2,
        LEN_4,
        LEN_8,
        LEN_ESC
    } t_len;

    // Classified job: tagged word (or raw value for the escape form) and its length
    typedef struct packed {
        logic [63:0] word;
        t_len        len;
    } t_job;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0]  ESC_BYTE   = 8'hF0;
    localparam logic [15:0] TAG_2      = 16'h8000;
    localparam logic [31:0] TAG_4      = 32'hC000_0000;
    localparam logic [63:0] TAG_8      = 64'hE000_0000_0000_0000;
    localparam logic        SIGNED_RST = 1'b1;

endpackage : pve_pkg
`default_nettype wire

// File: rtl/pve_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pve_front - range classifier
// Holds the signed_mode register, tests the incoming value against the four
// length ranges and builds the tagged word for the serialiser.
// ----------------------------------------------------------------------------
module pve_front
    import pve_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic [63:0] i_value_bits,
    output t_job             o_job
);

    logic r_signed_mode;
    logic fit1, fit2, fit4, fit8;
    logic [63:0] v;

    // Mode register; the user must write it only while idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= SIGNED_RST;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    assign v = i_value_bits;

    // Range tests: signed ranges via offset and unsigned compare
    always_comb begin
        if (r_signed_mode) begin
            fit1 = (v + 64'h40)                  < 64'h80;
            fit2 = (v + 64'h2000)                < 64'h4000;
            fit4 = (v + 64'h1000_0000)           < 64'h2000_0000;
            fit8 = (v + 64'h0800_0000_0000_0000) < 64'h1000_0000_0000_0000;
        end else begin
            fit1 = v < 64'h80;
            fit2 = v < 64'h4000;
            fit4 = v < 64'h2000_0000;
            fit8 = v < 64'h1000_0000_0000_0000;
        end
    end

    // Build tagged word, masking the value into its field
    always_comb begin
        priority if (fit1) begin
            o_job.len  = LEN_1;
            o_job.word = {57'd0, v[6:0]};
        end else if (fit2) begin
            o_job.len  = LEN_2;
            o_job.word = {48'd0, TAG_2 | {2'b00, v[13:0]}};
        end else if (fit4) begin
            o_job.len  = LEN_4;
            o_job.word = {32'd0, TAG_4 | {3'b000, v[28:0]}};
        end else if (fit8) begin
            o_job.len  = LEN_8;
            o_job.word = TAG_8 | {4'b0000, v[59:0]};
        end else begin
            o_job.len  = LEN_ESC;
            o_job.word = v;
        end
    end

endmodule : pve_front
`default_nettype wire

// File: rtl/pve_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pve_queue - short job queue
// Register-based FIFO that decouples the classifier from the serialiser.
// ----------------------------------------------------------------------------
module pve_queue
    import pve_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_take,
    output t_job      o_job,
    output logic      o_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_take;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_take) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_take) begin
                r_count <= r_count + 1'b1;
            end else if (do_take && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : pve_queue
`default_nettype wire

// File: rtl/pve_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pve_back - byte serialiser
// Loads one job, left-aligns its word and emits it a byte per pop, most
// significant first, with the escape byte ahead of raw values.
// ----------------------------------------------------------------------------
module pve_back
    import pve_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire logic       i_job_valid,
    output logic            o_take,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);

    logic [63:0] r_word, n_word;
    logic [3:0]  r_remain, n_remain;
    logic        r_esc, n_esc;
    logic        r_busy, n_busy;
    logic        done;

    assign o_empty    = !r_busy;
    assign o_last     = (r_remain == 4'd1);
    assign o_out_byte = r_esc ? ESC_BYTE : r_word[63:56];
    assign done       = !r_busy || (i_pop && o_last);
    assign o_take     = i_job_valid && done;

    // Next state: load a new job, step to the next byte, or go idle
    always_comb begin
        n_word   = r_word;
        n_remain = r_remain;
        n_esc    = r_esc;
        n_busy   = r_busy;
        if (o_take) begin
            n_busy = 1'b1;
            n_esc  = 1'b0;
            unique case (i_job.len)
                LEN_1: begin
                    n_word   = {i_job.word[7:0], 56'd0};
                    n_remain = 4'd1;
                end
                LEN_2: begin
                    n_word   = {i_job.word[15:0], 48'd0};
                    n_remain = 4'd2;
                end
                LEN_4: begin
                    n_word   = {i_job.word[31:0], 32'd0};
                    n_remain = 4'd4;
                end
                LEN_8: begin
                    n_word   = i_job.word;
                    n_remain = 4'd8;
                end
                LEN_ESC: begin
                    n_word   = i_job.word;
                    n_remain = 4'd9;
                    n_esc    = 1'b1;
                end
                default: begin
                    n_word   = i_job.word;
                    n_remain = 4'd8;
                end
            endcase
        end else if (r_busy && i_pop) begin
            if (o_last) begin
                n_busy = 1'b0;
            end
            n_remain = r_remain - 4'd1;
            if (r_esc) begin
                n_esc = 1'b0;
            end else begin
                n_word = {r_word[55:0], 8'd0};
            end
        end
    end

    // Hold control state; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_esc    <= 1'b0;
            r_remain <= '0;
        end else begin
            r_busy   <= n_busy;
            r_esc    <= n_esc;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule : pve_back
`default_nettype wire

// File: rtl/prefix_varint_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_varint_encoder - prefix-length variable integer encoder
// Encodes 64-bit integers into 1, 2, 4, 8 or 9 bytes, most significant first.
// ----------------------------------------------------------------------------
// Input channel: drive i_value_bits and push; the item is taken on a clock
// edge with push high and full low. Result channel: while empty is low,
// o_out_byte and o_last show the oldest waiting byte; pop takes it.
// o_last marks the final byte of each value's encoding.
// Configuration: i_cfg_we writes i_cfg_wdata into signed_mode (1 = signed
// ranges, 0 = unsigned); write only while no item is in flight.
// With the serialiser idle, an accepted item moves from the job queue into the
// serialiser registers, where its first byte shows and can be popped.
// Throughput: one byte per cycle on the result side while pop stays high; an
// item is 1, 2, 4, 8 or 9 bytes, sent by the byte-wide serialiser; the job
// queue lets new items be taken while the serialiser works.
// Reset: queue and serialiser empty, signed_mode set to 1.
// Stall: while pop is low the current byte holds; once the queue fills,
// full rises and further items wait.
// ----------------------------------------------------------------------------
module prefix_varint_encoder
    import pve_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] i_value_bits,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);

    t_job front_job, queue_job;
    logic queue_valid, take;

    pve_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_value_bits (i_value_bits),
        .o_job        (front_job)
    );

    pve_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_take  (take),
        .o_job   (queue_job),
        .o_valid (queue_valid)
    );

    pve_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_take      (take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule : prefix_varint_encoder
`default_nettype wire
